// File: hw/rtl/spcs_pkg.sv
// ----------------------------------------------------------------------------
// spcs_pkg: soft point constraint solver package
// Types, register indexes, sequencer steps and saturating helpers.
// ----------------------------------------------------------------------------
package spcs_pkg;

	localparam int unsigned CFG_AW = 3;

	localparam logic [CFG_AW-1:0] CFG_INV_MASS    = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_INV_INERTIA = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_GAMMA       = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_BIAS_RATE   = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_ANCHOR_X    = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_ANCHOR_Y    = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_TARGET_X    = 3'd6;
	localparam logic [CFG_AW-1:0] CFG_TARGET_Y    = 3'd7;

	localparam logic OP_PREPARE = 1'b0;
	localparam logic OP_SOLVE   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		SP_ROT_XA, SP_ARM_X, SP_ROT_YA, SP_ARM_Y,
		SP_K00_A, SP_K00, SP_K11_A, SP_K11,
		SP_OFF_A, SP_OFF, SP_DET_A, SP_DET,
		SP_EM0, SP_EM1, SP_EM3, SP_BIAS0, SP_BIAS1,
		SS_JX, SS_TX, SS_JY, SS_TY,
		SS_LX_A, SS_LX, SS_LY_A, SS_LY,
		SA_VX, SA_VY, SA_W_A, SA_W_B, SA_W
	} step_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} arith_req_t;

	typedef struct packed {
		logic done;
	} arith_rsp_t;

	function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
		if (v[64:31] == '0 || v[64:31] == '1)
			return v[31:0];
		return v[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] == v[31])
			return v[31:0];
		return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33({a[31], a} + {b[31], b});
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33({a[31], a} - {b[31], b});
	endfunction

	function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
		return sat33(33'sd0 - {a[31], a});
	endfunction

endpackage

// File: hw/rtl/spcs_arith.sv
// ----------------------------------------------------------------------------
// spcs_arith: bit-serial fixed-point multiply and divide
// Shift-add multiply (one bit a cycle) and restoring divide (one quotient
// bit a cycle) on magnitudes, with sign fix-up and saturation at the end.
// ----------------------------------------------------------------------------
module spcs_arith #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spcs_pkg::arith_req_t req,
	input  logic signed [31:0]  opa,
	input  logic signed [31:0]  opb,
	output spcs_pkg::arith_rsp_t rsp,
	output logic signed [31:0]  result
);
	import spcs_pkg::*;

	localparam int unsigned DW = 32 + FRAC_BITS;
	localparam int unsigned CW = $clog2(DW + 1);

	logic          busy_q, div_q, neg_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   hi_q, lo_q, mc_q;
	logic [31:0]   rem_q, dv_q;
	logic [DW-1:0] quo_q;
	logic signed [31:0] result_q;

	logic [31:0] ma, mb;
	logic [32:0] msum, r2, rn;
	logic        ge;
	logic signed [64:0] mag, sgn, fin;

	always_comb begin
		ma = opa[31] ? (~opa + 32'd1) : opa;
		mb = opb[31] ? (~opb + 32'd1) : opb;
		msum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : 33'd0);
		r2 = {rem_q, quo_q[DW-1]};
		ge = (r2 >= {1'b0, dv_q});
		rn = ge ? (r2 - {1'b0, dv_q}) : r2;
		if (div_q)
			mag = {{(65-DW){1'b0}}, quo_q};
		else
			mag = {1'b0, hi_q, lo_q};
		sgn = neg_q ? (65'sd0 - mag) : mag;
		fin = div_q ? sgn : (sgn >>> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= req.is_div;
				neg_q  <= opa[31] ^ opb[31];
				cnt_q  <= req.is_div ? CW'(DW) : CW'(32);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q  <= '0;
			lo_q  <= mb;
			mc_q  <= ma;
			rem_q <= '0;
			quo_q <= {ma, {FRAC_BITS{1'b0}}};
			dv_q  <= mb;
		end else if (busy_q && cnt_q != '0) begin
			if (div_q) begin
				rem_q <= rn[31:0];
				quo_q <= {quo_q[DW-2:0], ge};
			end else begin
				hi_q <= msum[32:1];
				lo_q <= {msum[0], lo_q[31:1]};
			end
		end
		if (busy_q && cnt_q == '0)
			result_q <= sat65(fin);
	end

	assign rsp.done = done_q;
	assign result   = result_q;

endmodule

// File: hw/rtl/soft_point_constraint_solver_core.sv
// ----------------------------------------------------------------------------
// soft_point_constraint_solver_core: 2D soft point constraint velocity solver
// Prepares the inverse effective mass and bias, and runs velocity solves.
// ----------------------------------------------------------------------------
// Usage:
//   Write the eight registers on cfg_we/cfg_addr/cfg_wdata while idle.
//   Send a request on in_valid/in_ready: operation 0 prepares (arm, inverse
//   effective mass, bias, optional warm start), operation 1 solves once.
//   Each request returns one result on out_valid/out_ready: velocities and
//   the accumulated impulse.
// Sequencing:
//   One request at a time; in_ready is high only while idle. All products
//   and quotients run on one shared bit-serial unit. A solve is 13
//   multiplies; a prepare is 14 multiplies and 3 divides, plus 5
//   multiplies with warm start.
// Reset:
//   Clears the registers, arm, inverse mass, bias and accumulated impulse.
// Stall:
//   The result holds on the outputs until out_ready; no new request is
//   taken before then.
// ----------------------------------------------------------------------------
module soft_point_constraint_solver_core #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [spcs_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic signed [17:0]  rot_cos,
	input  logic signed [17:0]  rot_sin,
	input  logic signed [31:0]  center_x,
	input  logic signed [31:0]  center_y,
	input  logic signed [31:0]  vel_in_x,
	input  logic signed [31:0]  vel_in_y,
	input  logic signed [31:0]  spin_in,
	input  logic                warm_start,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  vel_out_x,
	output logic signed [31:0]  vel_out_y,
	output logic signed [31:0]  spin_out,
	output logic signed [31:0]  impulse_out_x,
	output logic signed [31:0]  impulse_out_y
);
	import spcs_pkg::*;

	logic [30:0] im_q, ii_q, g_q, br_q;
	logic signed [31:0] ax_q, ay_q, tx_q, ty_q;

	logic signed [31:0] armx_q, army_q, em0_q, em1_q, em3_q, b0_q, b1_q;
	logic signed [31:0] acc0_q, acc1_q;

	logic               op_q, warm_q;
	logic signed [31:0] c_q, s_q, cx_q, cy_q, vx_q, vy_q, w_q;
	logic signed [31:0] ta_q, tb_q, lx_q, ly_q, k00_q, k11_q, off_q, det_q;

	state_t state_q, state_d;
	step_t  step_q, step_d;
	logic   last_step;

	arith_req_t req;
	arith_rsp_t rsp;
	logic signed [31:0] opa, opb, r;

	logic signed [31:0] im32, ii32, g32, br32, lx_op, ly_op;

	assign im32  = {1'b0, im_q};
	assign ii32  = {1'b0, ii_q};
	assign g32   = {1'b0, g_q};
	assign br32  = {1'b0, br_q};
	assign lx_op = (op_q == OP_SOLVE) ? lx_q : acc0_q;
	assign ly_op = (op_q == OP_SOLVE) ? ly_q : acc1_q;

	spcs_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.rsp    (rsp),
		.result (r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			im_q <= '0;
			ii_q <= '0;
			g_q  <= '0;
			br_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_INV_MASS:    im_q <= cfg_wdata[30:0];
				CFG_INV_INERTIA: ii_q <= cfg_wdata[30:0];
				CFG_GAMMA:       g_q  <= cfg_wdata[30:0];
				CFG_BIAS_RATE:   br_q <= cfg_wdata[30:0];
				CFG_ANCHOR_X:    ax_q <= cfg_wdata;
				CFG_ANCHOR_Y:    ay_q <= cfg_wdata;
				CFG_TARGET_X:    tx_q <= cfg_wdata;
				CFG_TARGET_Y:    ty_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// operand select for the shared unit
	always_comb begin
		opa = ii32;
		opb = armx_q;
		req.start  = (state_q == ST_ISSUE);
		req.is_div = 1'b0;
		unique case (step_q)
			SP_ROT_XA: begin opa = c_q; opb = ax_q; end
			SP_ARM_X:  begin opa = s_q; opb = ay_q; end
			SP_ROT_YA: begin opa = s_q; opb = ax_q; end
			SP_ARM_Y:  begin opa = c_q; opb = ay_q; end
			SP_K00_A:  begin opa = ii32; opb = army_q; end
			SP_K00:    begin opa = ta_q; opb = army_q; end
			SP_K11_A:  begin opa = ii32; opb = armx_q; end
			SP_K11:    begin opa = ta_q; opb = armx_q; end
			SP_OFF_A:  begin opa = ii32; opb = armx_q; end
			SP_OFF:    begin opa = ta_q; opb = army_q; end
			SP_DET_A:  begin opa = k00_q; opb = k11_q; end
			SP_DET:    begin opa = off_q; opb = off_q; end
			SP_EM0:    begin opa = k11_q; opb = det_q; req.is_div = 1'b1; end
			SP_EM1:    begin opa = qneg(off_q); opb = det_q; req.is_div = 1'b1; end
			SP_EM3:    begin opa = k00_q; opb = det_q; req.is_div = 1'b1; end
			SP_BIAS0:  begin opa = qsub(qadd(cx_q, armx_q), tx_q); opb = br32; end
			SP_BIAS1:  begin opa = qsub(qadd(cy_q, army_q), ty_q); opb = br32; end
			SS_JX:     begin opa = w_q; opb = army_q; end
			SS_TX:     begin opa = acc0_q; opb = g32; end
			SS_JY:     begin opa = w_q; opb = armx_q; end
			SS_TY:     begin opa = acc1_q; opb = g32; end
			SS_LX_A:   begin opa = em0_q; opb = ta_q; end
			SS_LX:     begin opa = em1_q; opb = tb_q; end
			SS_LY_A:   begin opa = em1_q; opb = ta_q; end
			SS_LY:     begin opa = em3_q; opb = tb_q; end
			SA_VX:     begin opa = lx_op; opb = im32; end
			SA_VY:     begin opa = ly_op; opb = im32; end
			SA_W_A:    begin opa = armx_q; opb = ly_op; end
			SA_W_B:    begin opa = army_q; opb = lx_op; end
			SA_W:      begin opa = ii32; opb = tb_q; end
			default: ;
		endcase
	end

	// step sequencing
	always_comb begin
		step_d = step_q;
		last_step = 1'b0;
		unique case (step_q)
			SP_BIAS1: begin
				if (warm_q)
					step_d = SA_VX;
				else
					last_step = 1'b1;
			end
			SS_LY: step_d = SA_VX;
			SA_W:  last_step = 1'b1;
			default: step_d = step_t'(step_q + 5'd1);
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_ISSUE;
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT:  if (rsp.done) state_d = last_step ? ST_OUT : ST_ISSUE;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= SP_ROT_XA;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready)
				step_q <= (operation == OP_SOLVE) ? SS_JX : SP_ROT_XA;
			else if (state_q == ST_WAIT && rsp.done)
				step_q <= step_d;
		end
	end

	// constraint state kept across requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armx_q <= '0;
			army_q <= '0;
			em0_q  <= '0;
			em1_q  <= '0;
			em3_q  <= '0;
			b0_q   <= '0;
			b1_q   <= '0;
			acc0_q <= '0;
			acc1_q <= '0;
		end else if (state_q == ST_WAIT && rsp.done) begin
			unique case (step_q)
				SP_ARM_X: armx_q <= qsub(ta_q, r);
				SP_ARM_Y: army_q <= qadd(ta_q, r);
				SP_EM0:   em0_q  <= (det_q == '0) ? '0 : r;
				SP_EM1:   em1_q  <= (det_q == '0) ? '0 : r;
				SP_EM3:   em3_q  <= (det_q == '0) ? '0 : r;
				SP_BIAS0: b0_q   <= r;
				SP_BIAS1: b1_q   <= r;
				SA_W: begin
					if (op_q == OP_SOLVE) begin
						acc0_q <= qadd(acc0_q, lx_q);
						acc1_q <= qadd(acc1_q, ly_q);
					end
				end
				default: ;
			endcase
		end
	end

	// request payload and working values
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= operation;
			warm_q <= warm_start;
			c_q    <= {{14{rot_cos[17]}}, rot_cos};
			s_q    <= {{14{rot_sin[17]}}, rot_sin};
			cx_q   <= center_x;
			cy_q   <= center_y;
			vx_q   <= vel_in_x;
			vy_q   <= vel_in_y;
			w_q    <= spin_in;
		end else if (state_q == ST_WAIT && rsp.done) begin
			case (step_q)
				SP_ROT_XA, SP_ROT_YA, SP_K00_A, SP_K11_A, SP_OFF_A, SP_DET_A, SA_W_A:
					ta_q <= r;
				SP_K00: k00_q <= qadd(qadd(im32, r), g32);
				SP_K11: k11_q <= qadd(qadd(im32, r), g32);
				SP_OFF: off_q <= qneg(r);
				SP_DET: det_q <= qsub(ta_q, r);
				SS_JX:  ta_q  <= qsub(vx_q, r);
				SS_TX:  ta_q  <= qneg(qadd(qadd(ta_q, b0_q), r));
				SS_JY:  tb_q  <= qadd(vy_q, r);
				SS_TY:  tb_q  <= qneg(qadd(qadd(tb_q, b1_q), r));
				SS_LX_A: lx_q <= r;
				SS_LX:   lx_q <= qadd(lx_q, r);
				SS_LY_A: ly_q <= r;
				SS_LY:   ly_q <= qadd(ly_q, r);
				SA_VX:  vx_q  <= qadd(vx_q, r);
				SA_VY:  vy_q  <= qadd(vy_q, r);
				SA_W_B: tb_q  <= qsub(ta_q, r);
				SA_W:   w_q   <= qadd(w_q, r);
				default: ;
			endcase
		end
	end

	assign vel_out_x     = vx_q;
	assign vel_out_y     = vy_q;
	assign spin_out      = w_q;
	assign impulse_out_x = acc0_q;
	assign impulse_out_y = acc1_q;

endmodule

// File: tb/sv/soft_point_constraint_solver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_point_constraint_solver_core_tb: self-checking testbench
// Drives prepare and solve requests under several register settings and
// random handshake stalls. A saturating fixed-point predictor computes the
// expected velocities and impulse for each request; results are compared
// field by field in order.
// ----------------------------------------------------------------------------
module soft_point_constraint_solver_core_tb;
	import spcs_pkg::*;

	localparam int FB = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] w;
		logic signed [31:0] ix;
		logic signed [31:0] iy;
	} solver_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_PREPARE;
	logic signed [17:0] rot_cos = '0;
	logic signed [17:0] rot_sin = '0;
	logic signed [31:0] center_x = '0;
	logic signed [31:0] center_y = '0;
	logic signed [31:0] vel_in_x = '0;
	logic signed [31:0] vel_in_y = '0;
	logic signed [31:0] spin_in = '0;
	logic warm_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] vel_out_x, vel_out_y, spin_out, impulse_out_x, impulse_out_y;

	soft_point_constraint_solver_core #(.FRAC_BITS(FB)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of registers and state
	logic signed [31:0] m_inv_mass, m_inv_inertia, m_gamma, m_bias_rate;
	logic signed [31:0] m_anchor_x, m_anchor_y, m_target_x, m_target_y;
	logic signed [31:0] m_arm_x, m_arm_y;
	logic signed [31:0] m_eff [4];
	logic signed [31:0] m_bias [2];
	logic signed [31:0] m_imp [2];

	solver_result_t expected_results[$];
	int errors = 0;
	int n_results = 0;
	int n_prepare = 0;
	int n_solve = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_recv = 1'b0;
	int idle_cycles = 0;

	function automatic logic signed [31:0] sat(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -66'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
		return sat(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
		return sat(66'(a) - 66'(b));
	endfunction

	function automatic logic signed [31:0] fx_neg(input logic signed [31:0] a);
		return sat(-66'(a));
	endfunction

	// arithmetic shift floors, matching round toward minus infinity
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return sat(p >>> FB);
	endfunction

	function automatic logic signed [31:0] fx_div(input logic signed [31:0] n, d);
		logic signed [65:0] num;
		num = 66'(n) <<< FB;
		return sat(num / 66'(d));
	endfunction

	function automatic logic signed [31:0] fx_cross(input logic signed [31:0] rx, ry, lx, ly);
		return fx_sub(fx_mul(rx, ly), fx_mul(ry, lx));
	endfunction

	function automatic void apply_impulse(input logic signed [31:0] lx, ly,
			inout solver_result_t r);
		r.vx = fx_add(r.vx, fx_mul(lx, m_inv_mass));
		r.vy = fx_add(r.vy, fx_mul(ly, m_inv_mass));
		r.w = fx_add(r.w, fx_mul(m_inv_inertia, fx_cross(m_arm_x, m_arm_y, lx, ly)));
	endfunction

	function automatic solver_result_t solve_constraint(input logic op,
			input logic signed [31:0] c, s, cx, cy, vx, vy, w, input logic ws);
		solver_result_t r;
		logic signed [31:0] k00, k11, off, det, jx, jy, tx, ty, lx, ly;
		r.vx = vx;
		r.vy = vy;
		r.w = w;
		if (op == OP_PREPARE) begin
			m_arm_x = fx_sub(fx_mul(c, m_anchor_x), fx_mul(s, m_anchor_y));
			m_arm_y = fx_add(fx_mul(s, m_anchor_x), fx_mul(c, m_anchor_y));
			k00 = fx_add(fx_add(m_inv_mass, fx_mul(fx_mul(m_inv_inertia, m_arm_y), m_arm_y)),
				m_gamma);
			k11 = fx_add(fx_add(m_inv_mass, fx_mul(fx_mul(m_inv_inertia, m_arm_x), m_arm_x)),
				m_gamma);
			off = fx_neg(fx_mul(fx_mul(m_inv_inertia, m_arm_x), m_arm_y));
			det = fx_sub(fx_mul(k00, k11), fx_mul(off, off));
			if (det == 0) begin
				foreach (m_eff[i]) m_eff[i] = '0;
			end else begin
				m_eff[0] = fx_div(k11, det);
				m_eff[1] = fx_div(fx_neg(off), det);
				m_eff[2] = m_eff[1];
				m_eff[3] = fx_div(k00, det);
			end
			m_bias[0] = fx_mul(fx_sub(fx_add(cx, m_arm_x), m_target_x), m_bias_rate);
			m_bias[1] = fx_mul(fx_sub(fx_add(cy, m_arm_y), m_target_y), m_bias_rate);
			if (ws) apply_impulse(m_imp[0], m_imp[1], r);
		end else begin
			jx = fx_sub(vx, fx_mul(w, m_arm_y));
			jy = fx_add(vy, fx_mul(w, m_arm_x));
			tx = fx_neg(fx_add(fx_add(jx, m_bias[0]), fx_mul(m_imp[0], m_gamma)));
			ty = fx_neg(fx_add(fx_add(jy, m_bias[1]), fx_mul(m_imp[1], m_gamma)));
			lx = fx_add(fx_mul(m_eff[0], tx), fx_mul(m_eff[1], ty));
			ly = fx_add(fx_mul(m_eff[2], tx), fx_mul(m_eff[3], ty));
			apply_impulse(lx, ly, r);
			m_imp[0] = fx_add(m_imp[0], lx);
			m_imp[1] = fx_add(m_imp[1], ly);
		end
		r.ix = m_imp[0];
		r.iy = m_imp[1];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] got, exp);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, exp);
		errors++;
	endtask

	// registers are only written while the block is idle
	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_INV_MASS: m_inv_mass = {1'b0, val[30:0]};
			CFG_INV_INERTIA: m_inv_inertia = {1'b0, val[30:0]};
			CFG_GAMMA: m_gamma = {1'b0, val[30:0]};
			CFG_BIAS_RATE: m_bias_rate = {1'b0, val[30:0]};
			CFG_ANCHOR_X: m_anchor_x = val;
			CFG_ANCHOR_Y: m_anchor_y = val;
			CFG_TARGET_X: m_target_x = val;
			default: m_target_y = val;
		endcase
		@(negedge clk);
	endtask

	task automatic send_request(input logic op, input logic signed [17:0] c, s,
			input logic signed [31:0] cx, cy, vx, vy, w, input logic ws);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		rot_cos <= c;
		rot_sin <= s;
		center_x <= cx;
		center_y <= cy;
		vel_in_x <= vx;
		vel_in_y <= vy;
		spin_in <= w;
		warm_start <= ws;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(solve_constraint(op, c, s, cx, cy, vx, vy, w, ws));
		if (op == OP_PREPARE) n_prepare++; else n_solve++;
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [17:0] rand_rot();
		case ($urandom_range(4))
			0: return 18'sd65536;
			1: return -18'sd65536;
			2: return 18'($urandom);
			default: return 18'($signed($urandom_range(0, 131072)) - 32'sd65536);
		endcase
	endfunction

	task automatic send_random(input logic op);
		send_request(op, rand_rot(), rand_rot(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), 1'($urandom_range(1)));
	endtask

	// one timestep: a prepare then a few solve iterations
	task automatic send_timestep();
		int iters;
		iters = $urandom_range(2, 6);
		send_random(OP_PREPARE);
		repeat (iters) send_random(OP_SOLVE);
	endtask

	task automatic load_physical_config();
		write_reg(CFG_INV_MASS, $urandom_range(32'h100, 32'h4_0000));
		write_reg(CFG_INV_INERTIA, $urandom_range(32'h100, 32'h4_0000));
		write_reg(CFG_GAMMA, $urandom_range(0, 32'h2_0000));
		write_reg(CFG_BIAS_RATE, $urandom_range(0, 32'h10_0000));
		write_reg(CFG_ANCHOR_X, $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
		write_reg(CFG_ANCHOR_Y, $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
		write_reg(CFG_TARGET_X, $urandom);
		write_reg(CFG_TARGET_Y, $urandom);
	endtask

	task automatic test_directed();
		// solve before any prepare uses the zero state
		send_request(OP_SOLVE, 0, 0, 0, 0, 32'sh1_0000, -32'sh1_0000, 32'sh7FFF_FFFF, 1'b1);
		// all-zero registers give a singular matrix
		send_request(OP_PREPARE, 18'sd65536, 0, 0, 0, 5, 6, 7, 1'b0);
		wait_drained();
		write_reg(CFG_INV_MASS, 32'h0001_0000);
		write_reg(CFG_INV_INERTIA, 32'h0002_0000);
		write_reg(CFG_GAMMA, 32'h0000_4000);
		write_reg(CFG_BIAS_RATE, 32'h0003_0000);
		write_reg(CFG_ANCHOR_X, 32'h0001_8000);
		write_reg(CFG_ANCHOR_Y, 32'hFFFF_0000);
		write_reg(CFG_TARGET_X, 32'h0005_0000);
		write_reg(CFG_TARGET_Y, 32'hFFFD_0000);
		send_request(OP_PREPARE, 18'sd65536, 0, 32'sh1_0000, 32'sh2_0000, 0, 0, 0, 1'b0);
		repeat (3) send_request(OP_SOLVE, 0, 0, 0, 0, 32'sh1000, -32'sh2000, 32'sh800, 1'b0);
		// warm start applies the impulse; solve ignores prepare-only fields
		send_request(OP_PREPARE, 18'sd46341, 18'sd46341, -32'sh3_0000, 32'sh1_0000,
			32'sh100, 32'sh200, -32'sh300, 1'b1);
		send_request(OP_SOLVE, -18'sd65536, 18'sd65536, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
		// rotation outside unit, unnormalized
		send_request(OP_PREPARE, 18'sh2_0000, 18'sd131071, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
		send_request(OP_SOLVE, 0, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		wait_drained();
		// extreme register values exercise saturation
		write_reg(CFG_INV_MASS, 32'h7FFF_FFFF);
		write_reg(CFG_INV_INERTIA, 32'hFFFF_FFFF);
		write_reg(CFG_GAMMA, 32'h7FFF_FFFF);
		write_reg(CFG_BIAS_RATE, 32'h7FFF_FFFF);
		write_reg(CFG_ANCHOR_X, 32'h8000_0000);
		write_reg(CFG_ANCHOR_Y, 32'h7FFF_FFFF);
		write_reg(CFG_TARGET_X, 32'h7FFF_FFFF);
		write_reg(CFG_TARGET_Y, 32'h8000_0000);
		send_request(OP_PREPARE, 18'sd65536, -18'sd65536, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, -1, 1, 1'b1);
		repeat (2) send_request(OP_SOLVE, 0, 0, 0, 0, -1, 1, 32'sh7FFF_FFFF, 1'b0);
		send_request(OP_PREPARE, 0, 0, 0, 0, 1, 2, 3, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_phase(input int n_items);
		int sent;
		sent = 0;
		load_physical_config();
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_random(1'($urandom_range(1)));
				sent++;
			end else begin
				send_timestep();
				sent += 5;
			end
		end
		wait_drained();
	endtask

	// receiver holds off while the sender keeps offering requests
	task automatic test_backpressure();
		hold_recv = 1'b1;
		fork
			repeat (4) send_timestep();
			begin
				repeat (3000) @(negedge clk);
				hold_recv = 1'b0;
			end
		join
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_recv)
			out_ready <= 1'b0;
		else
			out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			solver_result_t e;
			if (expected_results.size() == 0) begin
				$display("ERROR %0t: result with none expected", $time);
				errors++;
			end else begin
				e = expected_results.pop_front();
				n_results++;
				if (vel_out_x !== e.vx) report_mismatch("vel_out_x", vel_out_x, e.vx);
				if (vel_out_y !== e.vy) report_mismatch("vel_out_y", vel_out_y, e.vy);
				if (spin_out !== e.w) report_mismatch("spin_out", spin_out, e.w);
				if (impulse_out_x !== e.ix)
					report_mismatch("impulse_out_x", impulse_out_x, e.ix);
				if (impulse_out_y !== e.iy)
					report_mismatch("impulse_out_y", impulse_out_y, e.iy);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("soft_point_constraint_solver_core_tb failed");
			$finish;
		end
	end

	initial begin
		m_inv_mass = 0; m_inv_inertia = 0; m_gamma = 0; m_bias_rate = 0;
		m_anchor_x = 0; m_anchor_y = 0; m_target_x = 0; m_target_y = 0;
		m_arm_x = 0; m_arm_y = 0;
		foreach (m_eff[i]) m_eff[i] = 0;
		m_bias = '{0, 0};
		m_imp = '{0, 0};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		send_idle_pct = 15;
		recv_idle_pct = 72;
		test_random_phase(600);
		send_idle_pct = 72;
		recv_idle_pct = 15;
		test_random_phase(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_phase(600);
		$display("Covered %0d prepare and %0d solve requests, %0d results checked,",
			n_prepare, n_solve, n_results);
		$display("under zero, extreme and random register settings with stalls on both sides.");
		if (errors == 0)
			$display("soft_point_constraint_solver_core_tb passed");
		else
			$display("soft_point_constraint_solver_core_tb failed");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/spcs_pkg.sv
hw/rtl/spcs_arith.sv
hw/rtl/soft_point_constraint_solver_core.sv
tb/sv/soft_point_constraint_solver_core_tb.sv
